// ===== design/gha_pkg.sv =====
// Shared types and constants for the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int GEN_BITS  = 32;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int CMD_W     = 2;

  // Request queue between front and back end
  localparam int RQ_DEPTH  = 2;
  localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

  // Command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EXHAUSTED = 3'd1,
    STAT_INVALID   = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_STALE     = 3'd4
  } status_t;

  // Operation as classified by the front end
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_LOOKUP,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t                 op;
    status_t             err;
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
  } req_t;

endpackage

// ===== design/gha_in_if.sv =====
// Request channel interface: command and handle.
`timescale 1ns / 1ps

interface gha_in_if
  import gha_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IDX_W-1:0]    slot_index;
  logic [GEN_BITS-1:0] handle_generation;

  modport source (output valid, command, slot_index, handle_generation, input ready);
  modport sink   (input valid, command, slot_index, handle_generation, output ready);
endinterface

// ===== design/gha_out_if.sv =====
// Result channel interface: status, handle and live count.
`timescale 1ns / 1ps

interface gha_out_if
  import gha_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [IDX_W-1:0]    result_index;
  logic [GEN_BITS-1:0] result_generation;
  logic [CNT_W-1:0]    live_count;

  modport source (output valid, status, result_index, result_generation, live_count,
                  input ready);
  modport sink   (input valid, status, result_index, result_generation, live_count,
                  output ready);
endinterface

// ===== design/gha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/gha_front.sv =====
// Front end: accepts request beats, checks handles, queues classified requests.
`timescale 1ns / 1ps

module gha_front
  import gha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  gha_in_if.sink           in_ch,
  input  logic [CNT_W-1:0] cap,
  output logic             q_valid,
  output req_t             q_req,
  input  logic             q_pop
);

  req_t                fifo_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] cnt_r, cnt_nxt;
  req_t                cls;
  logic                push;

  // Classify the incoming beat: zero generation first, then index range
  always_comb begin
    cls.op  = OP_ALLOC;
    cls.err = STAT_OK;
    cls.idx = in_ch.slot_index;
    cls.gen = in_ch.handle_generation;
    unique case (in_ch.command) inside
      CMD_ALLOC: cls.op = OP_ALLOC;
      CMD_FREE, CMD_LOOKUP: begin
        if (in_ch.handle_generation == '0) begin
          cls.op  = OP_REJECT;
          cls.err = STAT_INVALID;
        end else if ({1'b0, in_ch.slot_index} >= cap) begin
          cls.op  = OP_REJECT;
          cls.err = STAT_RANGE;
        end else if (in_ch.command == CMD_FREE) begin
          cls.op = OP_FREE;
        end else begin
          cls.op = OP_LOOKUP;
        end
      end
      CMD_CLEAR: cls.op = OP_CLEAR;
      default:   cls.op = OP_CLEAR;
    endcase
  end

  assign in_ch.ready = (cnt_r != RQ_CNT_W'(RQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_req       = fifo_r[rd_ptr_r];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_r + RQ_PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_r + RQ_PTR_W'(1);
    end
    cnt_nxt = cnt_r + RQ_CNT_W'(push) - RQ_CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  // Queue never overfills and is never popped empty
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RQ_CNT_W'(RQ_DEPTH))
    else $error("request queue overfilled");

  a_q_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (cnt_r != '0))
    else $error("pop from empty request queue");

endmodule

// ===== design/gha_back.sv =====
// Back end: executes queued requests against the generation and free-stack RAMs.
`timescale 1ns / 1ps

module gha_back
  import gha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] cap,
  input  logic             pool_clear,
  input  logic             q_valid,
  input  req_t             q_req,
  output logic             q_pop,
  gha_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STK,
    ST_GEN
  } state_t;

  state_t              state_r, state_nxt;
  req_t                cur_r, cur_nxt;
  logic [CNT_W-1:0]    depth_r, depth_nxt;
  logic [CNT_W-1:0]    wmark_r, wmark_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [GEN_BITS-1:0] out_gen_r, out_gen_nxt;
  logic [CNT_W-1:0]    out_live_r, out_live_nxt;

  logic                gen_wr_en, gen_rd_en;
  logic [IDX_W-1:0]    gen_wr_addr, gen_rd_addr;
  logic [GEN_BITS-1:0] gen_wr_data, gen_rdata;
  logic                stk_wr_en, stk_rd_en;
  logic [IDX_W-1:0]    stk_wr_addr, stk_rd_addr, stk_wr_data, stk_rdata;

  logic                out_free, done;
  logic [CNT_W-1:0]    depth_dec;
  logic [GEN_BITS-1:0] gen_cur, gen_inc, alloc_gen;

  gha_ram #(.WIDTH(GEN_BITS), .DEPTH(MAX_SLOTS)) u_gen_ram (
    .clk     (clk),
    .wr_en   (gen_wr_en),
    .wr_addr (gen_wr_addr),
    .wr_data (gen_wr_data),
    .rd_en   (gen_rd_en),
    .rd_addr (gen_rd_addr),
    .rd_data (gen_rdata)
  );

  gha_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_stk_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rdata)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign depth_dec = depth_r - CNT_W'(1);

  // Slots at or above the watermark were never handed out since the last clear
  assign gen_cur   = ({1'b0, cur_r.idx} < wmark_r) ? gen_rdata : '0;
  assign gen_inc   = gen_cur + GEN_BITS'(1);
  assign alloc_gen = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    depth_nxt      = depth_r;
    wmark_nxt      = wmark_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_gen_nxt    = out_gen_r;
    out_live_nxt   = out_live_r;
    q_pop          = 1'b0;
    done           = 1'b0;
    gen_rd_en      = 1'b0;
    gen_rd_addr    = cur_r.idx;
    gen_wr_en      = 1'b0;
    gen_wr_addr    = cur_r.idx;
    gen_wr_data    = gen_inc;
    stk_rd_en      = 1'b0;
    stk_rd_addr    = depth_dec[IDX_W-1:0];
    stk_wr_en      = 1'b0;
    stk_wr_addr    = depth_r[IDX_W-1:0];
    stk_wr_data    = cur_r.idx;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_req.op) inside
            OP_ALLOC: begin
              if (depth_r != '0) begin
                // Pop the freed stack, then fetch the slot's generation
                q_pop     = 1'b1;
                stk_rd_en = 1'b1;
                cur_nxt   = q_req;
                state_nxt = ST_STK;
              end else if (out_free) begin
                q_pop = 1'b1;
                done  = 1'b1;
                if (wmark_r < cap) begin
                  // Fresh slot: generation is zero, so the new one is 1
                  gen_wr_en      = 1'b1;
                  gen_wr_addr    = wmark_r[IDX_W-1:0];
                  gen_wr_data    = GEN_BITS'(1);
                  wmark_nxt      = wmark_r + CNT_W'(1);
                  count_nxt      = count_r + CNT_W'(1);
                  out_status_nxt = STAT_OK;
                  out_idx_nxt    = wmark_r[IDX_W-1:0];
                  out_gen_nxt    = GEN_BITS'(1);
                end else begin
                  out_status_nxt = STAT_EXHAUSTED;
                  out_idx_nxt    = '0;
                  out_gen_nxt    = '0;
                end
              end
            end
            OP_FREE, OP_LOOKUP: begin
              q_pop       = 1'b1;
              gen_rd_en   = 1'b1;
              gen_rd_addr = q_req.idx;
              cur_nxt     = q_req;
              state_nxt   = ST_GEN;
            end
            OP_CLEAR: begin
              if (out_free) begin
                q_pop          = 1'b1;
                done           = 1'b1;
                depth_nxt      = '0;
                wmark_nxt      = '0;
                count_nxt      = '0;
                out_status_nxt = STAT_OK;
                out_idx_nxt    = '0;
                out_gen_nxt    = '0;
              end
            end
            default: begin
              if (out_free) begin
                q_pop          = 1'b1;
                done           = 1'b1;
                out_status_nxt = q_req.err;
                out_idx_nxt    = '0;
                out_gen_nxt    = '0;
              end
            end
          endcase
        end
      end

      ST_STK: begin
        gen_rd_en   = 1'b1;
        gen_rd_addr = stk_rdata;
        cur_nxt.idx = stk_rdata;
        state_nxt   = ST_GEN;
      end

      ST_GEN: begin
        if (out_free) begin
          done           = 1'b1;
          state_nxt      = ST_IDLE;
          out_status_nxt = STAT_STALE;
          out_idx_nxt    = '0;
          out_gen_nxt    = '0;
          case (cur_r.op)
            OP_ALLOC: begin
              gen_wr_en      = 1'b1;
              gen_wr_data    = alloc_gen;
              depth_nxt      = depth_dec;
              count_nxt      = count_r + CNT_W'(1);
              out_status_nxt = STAT_OK;
              out_idx_nxt    = cur_r.idx;
              out_gen_nxt    = alloc_gen;
            end
            OP_FREE: begin
              // Free with nothing live or a full stack answers stale
              if (gen_cur == cur_r.gen && count_r != '0 && depth_r < cap) begin
                gen_wr_en      = 1'b1;
                stk_wr_en      = 1'b1;
                depth_nxt      = depth_r + CNT_W'(1);
                count_nxt      = count_r - CNT_W'(1);
                out_status_nxt = STAT_OK;
                out_idx_nxt    = cur_r.idx;
              end
            end
            OP_LOOKUP: begin
              if (gen_cur == cur_r.gen) begin
                out_status_nxt = STAT_OK;
                out_idx_nxt    = cur_r.idx;
                out_gen_nxt    = gen_cur;
              end
            end
            default: begin
              out_status_nxt = STAT_STALE;
            end
          endcase
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (done) begin
      out_valid_nxt = 1'b1;
      out_live_nxt  = count_nxt;
    end

    // Capacity write empties the pool
    if (pool_clear) begin
      depth_nxt = '0;
      wmark_nxt = '0;
      count_nxt = '0;
    end
  end

  // State, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      wmark_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      wmark_r     <= wmark_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_gen_r    <= out_gen_nxt;
    out_live_r   <= out_live_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.result_index      = out_idx_r;
  assign out_ch.result_generation = out_gen_r;
  assign out_ch.live_count        = out_live_r;

  // Every slot below the watermark is either live or on the freed stack
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, depth_r} + {1'b0, count_r}) == {1'b0, wmark_r})
    else $error("slot accounting mismatch");

  a_wmark_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wmark_r <= cap)
    else $error("watermark beyond capacity");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("request popped while busy");

  a_alloc_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (done && cur_r.op == OP_ALLOC && state_r == ST_GEN) |=> (out_gen_r != '0))
    else $error("allocated a zero generation");

endmodule

// ===== design/generational_handle_allocator.sv =====
// Top level: capacity register, request front end and execution back end.
// A request waits in the front end queue. Clear, reject and fresh allocate finish in
//   the idle state; free and lookup first read the generation RAM, and allocate from
//   the freed stack pops the stack RAM ahead of that read. The back end takes a new
//   request only when done with the last; results are held until out_ch.ready.
// Reset (rst_n, synchronous): pool empty, capacity MAX_SLOTS; a capacity write clears.
`timescale 1ns / 1ps

module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  gha_in_if.sink           in_ch,
  gha_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic             q_valid, q_pop;
  req_t             q_req;

  // Clamp the written capacity to 1..MAX_SLOTS
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      if (cfg_data == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (cfg_data > CNT_W'(MAX_SLOTS)) begin
        cap_nxt = CNT_W'(MAX_SLOTS);
      end else begin
        cap_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(MAX_SLOTS);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  gha_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cap     (cap_r),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  gha_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap        (cap_r),
    .pool_clear (cfg_we),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/generational_handle_allocator_tb.sv =====
// Self-checking testbench for the generational handle allocator: directed and random traffic.
`timescale 1ns / 1ps

module generational_handle_allocator_tb;
  import gha_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;

  // One expected result beat
  typedef struct {
    status_t             status;
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
    logic [CNT_W-1:0]    live;
  } slot_result_t;

  // A handle the allocator has handed out and not yet taken back
  typedef struct {
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
  } handle_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_data;

  gha_in_if  in_ch ();
  gha_out_if out_ch ();

  generational_handle_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Allocator state as the testbench tracks it
  logic [GEN_BITS-1:0] gen_table [MAX_SLOTS];
  logic [IDX_W-1:0]    free_stack [MAX_SLOTS];
  int                  free_depth;
  int                  fresh_mark;
  int                  live_slots;
  int                  pool_cap;

  slot_result_t pending_results [$];
  handle_t      live_handles [$];
  int           error_count;
  bit           in_gaps;
  bit           out_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void reset_pool();
    foreach (gen_table[i]) gen_table[i] = '0;
    free_depth = 0;
    fresh_mark = 0;
    live_slots = 0;
    live_handles.delete();
  endfunction

  // Next result of the allocator for one request; updates the tracked state
  function automatic slot_result_t apply_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                                 logic [GEN_BITS-1:0] gen);
    slot_result_t        r;
    logic [IDX_W-1:0]    slot;
    logic [GEN_BITS-1:0] g;
    bit                  got;
    r.status = STAT_OK;
    r.idx    = '0;
    r.gen    = '0;
    got      = 1'b1;
    slot     = '0;
    case (cmd) inside
      CMD_ALLOC: begin
        if (free_depth > 0) begin
          free_depth--;
          slot = free_stack[free_depth];
        end else if (fresh_mark < pool_cap) begin
          slot = fresh_mark[IDX_W-1:0];
          fresh_mark++;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          g = gen_table[slot] + 1'b1;
          if (g == '0) g = GEN_BITS'(1);
          gen_table[slot] = g;
          live_slots++;
          r.idx = slot;
          r.gen = g;
        end else begin
          r.status = STAT_EXHAUSTED;
        end
      end
      CMD_FREE, CMD_LOOKUP: begin
        // zero generation, then range, then match
        if (gen == '0) begin
          r.status = STAT_INVALID;
        end else if (int'(idx) >= pool_cap) begin
          r.status = STAT_RANGE;
        end else if (gen_table[idx] != gen) begin
          r.status = STAT_STALE;
        end else if (cmd == CMD_FREE) begin
          if (live_slots == 0 || free_depth >= pool_cap) begin
            r.status = STAT_STALE;
          end else begin
            gen_table[idx] = gen_table[idx] + 1'b1;
            free_stack[free_depth] = idx;
            free_depth++;
            live_slots--;
            r.idx = idx;
          end
        end else begin
          r.idx = idx;
          r.gen = gen_table[idx];
        end
      end
      default: reset_pool();
    endcase
    r.live = live_slots[CNT_W-1:0];
    return r;
  endfunction

  // Drive one request beat; returns at the falling edge after it is taken
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                              logic [GEN_BITS-1:0] gen);
    slot_result_t r;
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.command           <= cmd;
    in_ch.slot_index        <= idx;
    in_ch.handle_generation <= gen;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    r = apply_request(cmd, idx, gen);
    pending_results.push_back(r);
    // keep the list of handles that are still good
    if (cmd == CMD_ALLOC && r.status == STAT_OK) begin
      live_handles.push_back('{r.idx, r.gen});
    end else if (cmd == CMD_FREE && r.status == STAT_OK) begin
      for (int k = live_handles.size() - 1; k >= 0; k--) begin
        if (live_handles[k].idx == idx) live_handles.delete(k);
      end
    end
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected beat is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Capacity write; the block clears the pool on it
  task automatic write_capacity(logic [CNT_W-1:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (value == '0) pool_cap = 1;
    else if (int'(value) > MAX_SLOTS) pool_cap = MAX_SLOTS;
    else pool_cap = int'(value);
    reset_pool();
  endtask

  // Slots come out in rising order after reset; lookups of fresh handles
  task automatic test_fresh_allocation();
    repeat (3) send_request(CMD_ALLOC, '0, '0);
    send_request(CMD_LOOKUP, 10'd1, 32'd1);
    send_request(CMD_LOOKUP, 10'd1023, 32'hFFFF_FFFF);
  endtask

  // Zero generation is reported before match
  task automatic test_check_order();
    send_request(CMD_LOOKUP, 10'd1023, 32'd0);
    send_request(CMD_FREE, 10'd0, 32'd0);
    send_request(CMD_LOOKUP, 10'd0, 32'hFFFF_FFFF);
  endtask

  // Freed slots are reused last-in first-out; double free and free with nothing live
  task automatic test_free_and_reuse();
    send_request(CMD_FREE, 10'd2, 32'd1);
    send_request(CMD_FREE, 10'd2, 32'd1);
    send_request(CMD_ALLOC, '0, '0);
    send_request(CMD_FREE, 10'd0, 32'd1);
    send_request(CMD_FREE, 10'd1, 32'd1);
    send_request(CMD_FREE, 10'd2, 32'd3);
    send_request(CMD_FREE, 10'd2, 32'd4);
  endtask

  // Capacity clamping, exhaustion, range errors and the clear command
  task automatic test_capacity_limits();
    write_capacity(11'd0);
    send_request(CMD_ALLOC, '0, '0);
    send_request(CMD_ALLOC, '0, '0);
    send_request(CMD_LOOKUP, 10'd1, 32'd5);
    send_request(CMD_LOOKUP, 10'd1, 32'd0);
    send_request(CMD_CLEAR, 10'h3FF, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, '0, '0);
    write_capacity(11'h7FF);
    send_request(CMD_LOOKUP, 10'd1023, 32'd1);
  endtask

  // Mostly well-formed alloc/free/lookup traffic on good handles, with some noise
  task automatic test_random_traffic(logic [CNT_W-1:0] cap, int count, bit gaps);
    handle_t             h;
    int                  pick;
    logic [IDX_W-1:0]    idx;
    logic [CMD_W-1:0]    cmd;
    logic [GEN_BITS-1:0] gen;
    write_capacity(cap);
    in_gaps  = gaps;
    out_gaps = gaps;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, MAX_SLOTS - 1);
      gen  = $urandom();
      cmd  = ($urandom_range(0, 1) == 0) ? CMD_FREE : CMD_LOOKUP;
      if (live_handles.size() != 0) h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      if (pick < 38 || (pick < 85 && live_handles.size() == 0)) begin
        send_request(CMD_ALLOC, idx, gen);
      end else if (pick < 62) begin
        send_request(CMD_FREE, h.idx, h.gen);
      end else if (pick < 77) begin
        send_request(CMD_LOOKUP, h.idx, h.gen);
      end else if (pick < 85) begin
        // stale: one generation bit flipped
        send_request(cmd, h.idx, h.gen ^ (32'd1 << $urandom_range(0, 31)));
      end else if (pick < 90) begin
        send_request(cmd, idx, gen);
      end else if (pick < 94) begin
        send_request(cmd, idx, '0);
      end else if (pick < 98) begin
        // handle forged from the current generation, freed slots included
        idx = $urandom_range(0, pool_cap - 1);
        send_request(cmd, idx, gen_table[idx]);
      end else begin
        send_request(CMD_CLEAR, idx, gen);
      end
    end
  endtask

  // Result beat ready, with random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_gaps && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [GEN_BITS-1:0] expv, logic [GEN_BITS-1:0] act);
    if (expv !== act) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, expv, act);
      error_count++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  initial begin
    slot_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, got status %0d idx %0d",
                   $time, out_ch.status, out_ch.result_index);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", GEN_BITS'(want.status), GEN_BITS'(out_ch.status));
          check_field("result_index", GEN_BITS'(want.idx), GEN_BITS'(out_ch.result_index));
          check_field("result_generation", want.gen, out_ch.result_generation);
          check_field("live_count", GEN_BITS'(want.live), GEN_BITS'(out_ch.live_count));
        end
      end
    end
  end

  // Watchdog: too long with no beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_data                = '0;
    in_ch.valid             = 1'b0;
    in_ch.command           = CMD_ALLOC;
    in_ch.slot_index        = '0;
    in_ch.handle_generation = '0;
    error_count             = 0;
    in_gaps                 = 1'b1;
    out_gaps                = 1'b1;
    pool_cap                = MAX_SLOTS;
    foreach (free_stack[i]) free_stack[i] = '0;
    reset_pool();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_fresh_allocation();
    test_check_order();
    test_free_and_reuse();
    test_capacity_limits();
    test_random_traffic(11'd4, 250, 1'b1);
    test_random_traffic(11'd1024, 300, 1'b1);
    test_random_traffic(CNT_W'($urandom_range(1, 32)), 300, 1'b1);
    test_random_traffic(11'd0, 100, 1'b1);
    test_random_traffic(CNT_W'($urandom_range(0, 2047)), 250, 1'b1);
    test_random_traffic(11'd8, 300, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== generational_handle_allocator.f =====
design/gha_pkg.sv
design/gha_in_if.sv
design/gha_out_if.sv
design/gha_ram.sv
design/gha_front.sv
design/gha_back.sv
design/generational_handle_allocator.sv
tb/generational_handle_allocator_tb.sv
